// ===== src/acsd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acsd_pkg
// Shared types and constants of the ADC channel scan decoder.
// ----------------------------------------------------------------------------
package acsd_pkg;

    localparam int SETUP_REGS  = 4;
    localparam int SETUP_W     = 13;
    localparam int ENABLE_BIT  = 12;
    localparam int SPEED_HI    = 11;
    localparam int SPEED_LO    = 8;
    localparam int SELECT_W    = 8;
    localparam int RAW_W       = 32;
    localparam int COUNT_W     = 25;
    localparam int CHAN_OUT_W  = 2;
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;
    localparam int OUT_TDATA_W = 72;

    localparam logic [1:0] REG_CHAN0_SETUP = 2'd0;
    localparam logic [1:0] REG_CHAN1_SETUP = 2'd1;
    localparam logic [1:0] REG_CHAN2_SETUP = 2'd2;
    localparam logic [1:0] REG_CHAN3_SETUP = 2'd3;

    localparam logic signed [COUNT_W-1:0] PEAK_RESET = {1'b1, {(COUNT_W-1){1'b0}}};

    typedef logic [SETUP_W-1:0]        setup_t;
    typedef logic signed [COUNT_W-1:0] count_t;

    typedef struct packed {
        setup_t [SETUP_REGS-1:0] setup;
    } cfg_t;

endpackage
`default_nettype wire

// ===== src/adc_channel_scan_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adc_channel_scan_decoder
// Decodes converter transfer words, tracks per-channel peaks and selects the
// next channel of a round-robin scan.
// ----------------------------------------------------------------------------
// Each request on the slave stream is one 32-bit converter word. The block
// credits its decoded count to the current channel, updates that channel's
// peak, and emits one request on the master stream with the command bytes of
// the next enabled channel, which then becomes current. When no channel is
// enabled the word is consumed and no request is emitted.
// The datapath is an input register followed by a result register, and one
// word can be taken every cycle unless the receiver stalls. The round-robin
// pick over the enable bits and the peak compare sit in the single stage
// between the two registers. When the receiver stalls, the result register
// holds its request and the input register still takes one more word; the
// slave side then stalls too. Reset clears all setup registers, selects
// channel 0 and sets every peak to the most negative count. Setup must
// be written over APB only while the stream is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module adc_channel_scan_decoder #(
    parameter int CHANNELS = 4
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [acsd_pkg::ADDR_W-1:0]      paddr,
    input  wire logic [acsd_pkg::DATA_W-1:0]      pwdata,
    output logic      [acsd_pkg::DATA_W-1:0]      prdata,
    output logic                                  pready,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // raw_word[31:0]
    input  wire logic [acsd_pkg::RAW_W-1:0]       s_tdata,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // sample_channel[1:0], sample_count[26:2], new_peak[27], peak_value[52:28],
    // next_channel[54:53], select_byte[62:55], speed_byte[70:63], zero[71]
    output logic      [acsd_pkg::OUT_TDATA_W-1:0] m_tdata,
    // sample_valid[0]
    output logic                                  m_tuser
);

    localparam int CW = $clog2(CHANNELS);

    acsd_pkg::cfg_t              cfg;
    acsd_pkg::setup_t            chan_setup [CHANNELS];
    logic [CHANNELS-1:0]         en_vec;

    logic                        s1_valid_reg;
    logic [acsd_pkg::RAW_W-1:0]  s1_word_reg;
    logic                        m_valid_reg;
    logic [acsd_pkg::OUT_TDATA_W-1:0] m_data_reg;
    logic                        m_user_reg;
    logic [CW-1:0]               cur_reg;
    logic [CW-1:0]               cur_next;
    acsd_pkg::count_t            peak_reg [CHANNELS];

    logic                        advance;
    logic                        process_item;
    logic                        found;
    logic [CW:0]                 cand;
    acsd_pkg::count_t            count;
    acsd_pkg::count_t            cur_peak;
    acsd_pkg::count_t            peak_out;
    logic                        cur_enabled;
    logic                        peak_flag;
    acsd_pkg::setup_t            nxt_setup;
    logic [acsd_pkg::OUT_TDATA_W-1:0] result;

    acsd_regs #(
        .CHANNELS (CHANNELS)
    ) u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Channels without a setup register stay disabled.
    for (genvar g = 0; g < CHANNELS; g++)
    begin : g_chan
        if (g < acsd_pkg::SETUP_REGS)
        begin : g_setup
            assign chan_setup[g] = cfg.setup[g];
        end
        else
        begin : g_none
            assign chan_setup[g] = '0;
        end
        assign en_vec[g] = chan_setup[g][acsd_pkg::ENABLE_BIT];
    end

    assign advance      = !m_valid_reg || m_tready;
    assign s_tready     = !s1_valid_reg || advance;
    assign process_item = s1_valid_reg && advance;

    // Round-robin search starting after the current channel, current last.
    always_comb
    begin
        found    = 1'b0;
        cur_next = '0;
        cand     = '0;
        for (int i = 1; i <= CHANNELS; i++)
        begin
            cand = {1'b0, cur_reg} + (CW+1)'(i);
            if (cand >= (CW+1)'(CHANNELS))
            begin
                cand = cand - (CW+1)'(CHANNELS);
            end
            if (!found && en_vec[cand[CW-1:0]])
            begin
                found    = 1'b1;
                cur_next = cand[CW-1:0];
            end
        end
    end

    // Bit 29 high means a non-negative count; low means the count minus 2^24.
    assign count       = {~s1_word_reg[29], s1_word_reg[28:5]};
    assign cur_enabled = en_vec[cur_reg];
    assign cur_peak    = peak_reg[cur_reg];
    assign peak_flag   = cur_enabled && (count > cur_peak);
    assign nxt_setup   = chan_setup[cur_next];

    always_comb
    begin
        if (!cur_enabled)
        begin
            peak_out = '0;
        end
        else if (peak_flag)
        begin
            peak_out = count;
        end
        else
        begin
            peak_out = cur_peak;
        end
    end

    assign result = {
        1'b0,
        nxt_setup[acsd_pkg::SPEED_HI:acsd_pkg::SPEED_LO], 4'b0000,
        nxt_setup[acsd_pkg::SELECT_W-1:0],
        acsd_pkg::CHAN_OUT_W'(cur_next),
        peak_out,
        peak_flag,
        count,
        acsd_pkg::CHAN_OUT_W'(cur_reg)
    };

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            s1_word_reg <= s_tdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            cur_reg     <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                peak_reg[i] <= acsd_pkg::PEAK_RESET;
            end
        end
        else if (process_item && found)
        begin
            m_valid_reg <= 1'b1;
            cur_reg     <= cur_next;
            if (peak_flag)
            begin
                peak_reg[cur_reg] <= count;
            end
        end
        else if (advance)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (process_item && found)
        begin
            m_data_reg <= result;
            m_user_reg <= cur_enabled;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule
`default_nettype wire

// ===== src/acsd_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acsd_regs
// APB register file holding the per-channel setup words.
// ----------------------------------------------------------------------------
module acsd_regs #(
    parameter int CHANNELS = 4
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [acsd_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [acsd_pkg::DATA_W-1:0]  pwdata,
    output logic      [acsd_pkg::DATA_W-1:0]  prdata,
    output logic                              pready,
    output acsd_pkg::cfg_t                    cfg
);

    acsd_pkg::setup_t setup_reg [acsd_pkg::SETUP_REGS];
    logic [1:0]       reg_index;
    logic             wr_en;

    assign reg_index = paddr[acsd_pkg::ADDR_W-1:2];
    assign wr_en     = psel && penable && pwrite && (int'(reg_index) < CHANNELS);
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < acsd_pkg::SETUP_REGS; i++)
            begin
                setup_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            setup_reg[reg_index] <= pwdata[acsd_pkg::SETUP_W-1:0];
        end
    end

    always_comb
    begin
        unique case (reg_index)
            acsd_pkg::REG_CHAN0_SETUP: prdata = 32'(setup_reg[0]);
            acsd_pkg::REG_CHAN1_SETUP: prdata = 32'(setup_reg[1]);
            acsd_pkg::REG_CHAN2_SETUP: prdata = 32'(setup_reg[2]);
            acsd_pkg::REG_CHAN3_SETUP: prdata = 32'(setup_reg[3]);
            default:                   prdata = '0;
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < acsd_pkg::SETUP_REGS; i++)
        begin
            cfg.setup[i] = setup_reg[i];
        end
    end

endmodule
`default_nettype wire

// ===== src/acsd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acsd_checker
// Port-level checks of the ADC channel scan decoder, bound to the top level.
// ----------------------------------------------------------------------------
module acsd_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             s_tready,
    input wire logic                             m_tvalid,
    input wire logic                             m_tready,
    input wire logic [acsd_pkg::OUT_TDATA_W-1:0] m_tdata,
    input wire logic                             m_tuser
);

    // A stalled result request holds its contents.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result request changed while stalled");

    // An empty output stage never stalls the input.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // A sample for a disabled channel carries no peak.
    a_nopeak: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> !m_tdata[27] && (m_tdata[52:28] == '0))
        else $error("peak reported for disabled channel");

    // A new peak equals the sample that set it.
    a_newpeak: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[27] |-> m_tuser && (m_tdata[52:28] == m_tdata[26:2]))
        else $error("new peak does not match sample");

    // Each result belongs to the channel announced by the one before it.
    a_chain: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready) ##1 m_tvalid |-> m_tdata[1:0] == $past(m_tdata[54:53]))
        else $error("sample channel breaks the scan order");

endmodule

bind adc_channel_scan_decoder acsd_checker u_acsd_checker (.*);
`default_nettype wire
